>>> src/s4acl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package s4acl_pkg;

	localparam int NUM_RULES_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] REPLY_GRANTED  = 8'h5A;
	localparam logic [7:0] REPLY_REJECTED = 8'h5B;
	localparam logic [7:0] CMD_CONNECT    = 8'h01;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	localparam logic [1:0] MODE_BOTH         = 2'd0;
	localparam logic [1:0] MODE_CONNECT_ONLY = 2'd1;
	localparam logic [1:0] MODE_BIND_ONLY    = 2'd2;

	typedef struct packed {
		logic        action;
		logic [3:0]  rule_index;
		logic        rule_enable;
		logic [1:0]  rule_mode;
		logic [31:0] rule_address;
		logic [7:0]  request_command;
		logic [15:0] dest_port;
		logic [31:0] dest_ip;
	} item_t;

	typedef struct packed {
		logic [7:0]  reply_code;
		logic [15:0] reply_port;
		logic [31:0] reply_ip;
		logic        accepted;
	} result_t;

	// classified operation handed from front to back
	typedef struct packed {
		logic        is_check;
		logic        is_connect;
		logic [3:0]  slot;
		logic        enable;
		logic [1:0]  mode;
		logic [31:0] rule_addr;
		logic [15:0] dport;
		logic [31:0] dip;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	function automatic logic mode_allows(input logic [1:0] mode, input logic is_connect);
		logic ok;
		case (mode)
			MODE_CONNECT_ONLY: ok = is_connect;
			MODE_BIND_ONLY:    ok = !is_connect;
			default:           ok = 1'b1;
		endcase
		return ok;
	endfunction

	// zero octet in the pattern is a wildcard
	function automatic logic addr_matches(input logic [31:0] pattern, input logic [31:0] addr);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (pattern[8*k +: 8] != 8'd0 && pattern[8*k +: 8] != addr[8*k +: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

>>> src/s4acl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module s4acl_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire s4acl_pkg::item_t  item,
	output logic                   full,
	input  wire s4acl_pkg::q_status_t q_stat,
	output logic                   q_push,
	output s4acl_pkg::op_t         q_data
);
	import s4acl_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	logic take;

	assign q_push = valid_s1 && !q_stat.full;
	assign full   = valid_s1 && q_stat.full;
	assign take   = push && !full;
	assign q_data = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1.is_check   <= (item.action == ACT_CHECK);
			op_s1.is_connect <= (item.request_command == CMD_CONNECT);
			op_s1.slot       <= item.rule_index;
			op_s1.enable     <= item.rule_enable;
			op_s1.mode       <= item.rule_mode;
			op_s1.rule_addr  <= item.rule_address;
			op_s1.dport      <= item.dest_port;
			op_s1.dip        <= item.dest_ip;
		end
	end

endmodule

`default_nettype wire

>>> src/s4acl_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module s4acl_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire s4acl_pkg::q_ctrl_t   ctrl,
	input  wire s4acl_pkg::op_t       wdata,
	output s4acl_pkg::op_t            rdata,
	output s4acl_pkg::q_status_t      stat
);
	import s4acl_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctrl.push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (ctrl.pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (ctrl.push && !ctrl.pop)
				count_q <= count_q + CNT_W'(1);
			else if (ctrl.pop && !ctrl.push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push)
			slots_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

>>> src/s4acl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module s4acl_back #(
	parameter int NUM_RULES = s4acl_pkg::NUM_RULES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [15:0]          bind_port,
	input  wire s4acl_pkg::q_status_t q_stat,
	input  wire s4acl_pkg::op_t       q_data,
	output logic                      q_pop,
	output logic                      empty,
	input  wire logic                 pop,
	output s4acl_pkg::result_t        result
);
	import s4acl_pkg::*;

	localparam int IDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_REPLY = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             hit_q;
	logic             pend_q;
	logic             rvalid_q;
	logic [33:0]      rdata_q;
	op_t              req_q;
	logic             out_valid_q;
	result_t          out_q;

	logic [33:0]      rule_mem [NUM_RULES];
	logic             rule_valid_q [NUM_RULES];

	logic             is_load;
	logic             slot_ok;
	logic [IDX_W+3:0] slot_ext;
	logic [IDX_W-1:0] waddr;
	logic             we;
	logic             cnt_last;
	logic             rule_hit;
	logic             reply_go;

	assign is_load  = (state_q == ST_IDLE) && !q_stat.empty && !q_data.is_check;
	assign q_pop    = (state_q == ST_IDLE) && !q_stat.empty;
	assign slot_ok  = (int'(q_data.slot) < NUM_RULES);
	assign slot_ext = (IDX_W + 4)'(q_data.slot);
	assign waddr    = slot_ext[IDX_W-1:0];
	assign we       = is_load && slot_ok;
	assign cnt_last = (cnt_q == IDX_W'(NUM_RULES - 1));
	// table entry: mode in the top two bits, address below
	assign rule_hit = pend_q && rvalid_q &&
		mode_allows(rdata_q[33:32], req_q.is_connect) &&
		addr_matches(rdata_q[31:0], req_q.dip);
	assign reply_go = (state_q == ST_REPLY) && (!out_valid_q || pop);

	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (we)
			rule_mem[waddr] <= {q_data.mode, q_data.rule_addr};
		rdata_q <= rule_mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RULES; i++)
				rule_valid_q[i] <= 1'b0;
		end else if (we) begin
			rule_valid_q[waddr] <= q_data.enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			pend_q      <= 1'b0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_q <= rule_valid_q[cnt_q];
			if (rule_hit)
				hit_q <= 1'b1;
			if (reply_go)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_data.is_check) begin
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// read issued this cycle is judged next cycle
					pend_q <= 1'b1;
					if (cnt_last)
						state_q <= ST_FLUSH;
					else
						cnt_q <= cnt_q + IDX_W'(1);
				end
				ST_FLUSH: begin
					pend_q  <= 1'b0;
					state_q <= ST_REPLY;
				end
				ST_REPLY: begin
					if (reply_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.is_check)
			req_q <= q_data;
		if (reply_go) begin
			out_q.reply_code <= hit_q ? REPLY_GRANTED : REPLY_REJECTED;
			out_q.reply_port <= req_q.is_connect ? req_q.dport : bind_port;
			out_q.reply_ip   <= req_q.is_connect ? req_q.dip : 32'd0;
			out_q.accepted   <= hit_q;
		end
	end

endmodule

`default_nettype wire

>>> src/socks4_request_acl_check_core.sv
// channel  | ports                    | transaction when
// ---------+--------------------------+-------------------------
// request  | push, full, item         | push && !full
// reply    | pop, empty, result       | pop && !empty
// config   | cfg_valid, cfg_ready,    | cfg_valid && cfg_ready
//          | cfg_data                 |
//
// A load passes from push through the front register and the queue to the table
// write in the back, and the back is free again the next cycle.
// A check occupies the back for the pop, one table read per rule, a flush state
// to judge the last read, and the reply state that loads the reply.
// The front and the two-entry queue keep taking items while the back scans.
// arst_n clears all rule valid marks, bind_port and all queues; no sweep.
// A full reply register holds the back in its reply state until popped.
`timescale 1ns / 1ps
`default_nettype none

module socks4_request_acl_check_core #(
	parameter int NUM_RULES = s4acl_pkg::NUM_RULES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire s4acl_pkg::item_t    item,
	output logic                     empty,
	input  wire logic                pop,
	output s4acl_pkg::result_t       result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [15:0]         cfg_data
);
	import s4acl_pkg::*;

	logic [15:0] bind_port_q;
	q_status_t   q_stat;
	q_ctrl_t     q_ctrl;
	logic        q_push;
	logic        q_pop;
	op_t         q_wdata;
	op_t         q_rdata;

	assign cfg_ready = 1'b1;
	assign q_ctrl    = '{push: q_push, pop: q_pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bind_port_q <= '0;
		else if (cfg_valid && cfg_ready)
			bind_port_q <= cfg_data;
	end

	s4acl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_stat (q_stat),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	s4acl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.wdata  (q_wdata),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	s4acl_back #(
		.NUM_RULES (NUM_RULES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.bind_port (bind_port_q),
		.q_stat    (q_stat),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctrl.push |-> !q_stat.full)
		else $error("queue written while full");

	a_q_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctrl.pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_code_matches_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((result.accepted && result.reply_code == REPLY_GRANTED) ||
			(!result.accepted && result.reply_code == REPLY_REJECTED)))
		else $error("reply code disagrees with accepted flag");
`endif

endmodule

`default_nettype wire
